[hdl/mpbm_pkg.sv]
// shared types and constants for the multi-pattern byte matcher
package mpbm_pkg;

	localparam int NODE_COUNT    = 256;
	localparam int NODE_W        = $clog2(NODE_COUNT);
	localparam int PATTERN_COUNT = 64;
	localparam int ID_W          = 6;

	localparam logic [2:0] CMD_CLEAR   = 3'd0;
	localparam logic [2:0] CMD_PATTERN = 3'd1;
	localparam logic [2:0] CMD_BUILD   = 3'd2;
	localparam logic [2:0] CMD_SCAN    = 3'd3;
	localparam logic [2:0] CMD_END     = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_MATCH = 2'd2;
	localparam logic [1:0] ST_CLEAN = 2'd3;

	typedef struct packed {
		logic [2:0]      cmd;
		logic [7:0]      data_byte;
		logic            pattern_end;
		logic [ID_W-1:0] pattern_id;
	} item_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [ID_W-1:0] match_id;
		logic            last;
	} result_t;

endpackage

[hdl/mpbm_ram.sv]
// generic single-write, single-read ram with registered read data
module mpbm_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/multi_pattern_byte_matcher.sv]
// aho-corasick matcher top level: command sequencer around the trie memories
//
// One command is taken when start is high and busy is low; results appear on
// result for one cycle each, marked by strobe, and the receiver cannot stall
// them. Clear and unused commands are answered straight from idle. Pattern,
// scan and build work runs through one trie edge lookup (goto read, then
// parent check read). A pattern byte does one lookup, then follows or adds
// the edge, or reports full. A scan byte does one lookup per node tried on
// the failure path, then walks the output chain. End of stream reports clean
// straight from idle when nothing was detected, else it checks one id per
// cycle. Build links does one lookup per byte value per node, root included,
// plus the failure searches. The memories need no clearing after reset or
// clear: an edge counts only when its child lies below the node count and
// records this node and byte as its parent.
module multi_pattern_byte_matcher
	import mpbm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    strobe,
	output result_t result
);

	typedef enum logic [4:0] {
		IDLE, L_GOTO, L_PRT, L_CHK, NN_CHK, NN_FW, INS_DO, S_SET, S_T, S_R,
		E_W, B_LK, B_EDGE, B_WR, B_NEXTB, B_POP, B_U, B_FU
	} state_t;

	state_t            state_q, ret_q, nret_q;
	item_t             item_q;
	logic [NODE_W:0]   nc_q, head_q, tail_q;
	logic [NODE_W-1:0] cursor_q, scan_q, n_q, c_q, edge_q, res_q, t_q;
	logic [NODE_W-1:0] u_q, fu_q, ch_q;
	logic [7:0]        b_q, bb_q;
	logic              root_q;
	logic [63:0]       mask_q, rem;
	logic [ID_W-1:0]   id_q;

	logic                   goto_we, prt_we, fail_we, tag_we, q_we;
	logic [NODE_W+7:0]      goto_waddr, goto_raddr;
	logic [NODE_W-1:0]      goto_rdata, new_node;
	logic [NODE_W+7:0]      prt_rdata;
	logic [NODE_W-1:0]      fail_waddr, fail_wdata, fail_raddr, fail_rdata;
	logic [NODE_W-1:0]      tag_waddr;
	logic [6:0]             tag_wdata, tag_rdata;
	logic [NODE_W-1:0]      q_rdata;
	logic                   full, id_ok, tagging;

	assign new_node = nc_q[NODE_W-1:0];
	assign full     = (nc_q == (NODE_W+1)'(NODE_COUNT));
	assign id_ok    = ({1'b0, item_q.pattern_id} < 7'(PATTERN_COUNT));
	assign tagging  = item_q.pattern_end && id_ok;
	assign rem      = mask_q & ~(64'd1 << id_q);
	assign busy     = (state_q != IDLE);

	always_comb begin
		goto_we    = (state_q == INS_DO) && (edge_q == '0) && !full;
		prt_we     = goto_we;
		goto_waddr = {cursor_q, item_q.data_byte};
		goto_raddr = {n_q, b_q};
		fail_we    = 1'b0;
		fail_waddr = new_node;
		fail_wdata = '0;
		tag_we     = 1'b0;
		tag_waddr  = (edge_q != '0) ? edge_q : new_node;
		tag_wdata  = tagging ? {1'b1, item_q.pattern_id} : 7'd0;
		q_we       = 1'b0;
		case (state_q)
			INS_DO: begin
				fail_we = goto_we;
				tag_we  = goto_we || ((edge_q != '0) && tagging);
			end
			B_EDGE: begin
				q_we       = (edge_q != '0) && (tail_q < (NODE_W+1)'(NODE_COUNT));
				fail_we    = (edge_q != '0) && root_q;
				fail_waddr = edge_q;
			end
			B_WR: begin
				fail_we    = 1'b1;
				fail_waddr = ch_q;
				fail_wdata = res_q;
			end
			default: ;
		endcase
		case (state_q)
			S_T:     fail_raddr = t_q;
			B_U:     fail_raddr = q_rdata;
			default: fail_raddr = n_q;
		endcase
	end

	mpbm_ram #(.Width(NODE_W), .Depth(NODE_COUNT*256)) u_goto (
		.clk(clk), .we(goto_we), .waddr(goto_waddr), .wdata(new_node),
		.raddr(goto_raddr), .rdata(goto_rdata)
	);

	// parent node and byte of each child, validates goto entries
	mpbm_ram #(.Width(NODE_W+8), .Depth(NODE_COUNT)) u_prt (
		.clk(clk), .we(prt_we), .waddr(new_node), .wdata(goto_waddr),
		.raddr(goto_rdata), .rdata(prt_rdata)
	);

	mpbm_ram #(.Width(NODE_W), .Depth(NODE_COUNT)) u_fail (
		.clk(clk), .we(fail_we), .waddr(fail_waddr), .wdata(fail_wdata),
		.raddr(fail_raddr), .rdata(fail_rdata)
	);

	mpbm_ram #(.Width(7), .Depth(NODE_COUNT)) u_tag (
		.clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
		.raddr(t_q), .rdata(tag_rdata)
	);

	mpbm_ram #(.Width(NODE_W), .Depth(NODE_COUNT)) u_queue (
		.clk(clk), .we(q_we), .waddr(tail_q[NODE_W-1:0]), .wdata(edge_q),
		.raddr(head_q[NODE_W-1:0]), .rdata(q_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			ret_q    <= IDLE;
			nret_q   <= IDLE;
			nc_q     <= (NODE_W+1)'(1);
			cursor_q <= '0;
			scan_q   <= '0;
			mask_q   <= '0;
			strobe   <= 1'b0;
			result   <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			root_q   <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				IDLE: begin
					if (start) begin
						item_q <= item;
						case (item.cmd)
							CMD_CLEAR: begin
								nc_q     <= (NODE_W+1)'(1);
								cursor_q <= '0;
								scan_q   <= '0;
								mask_q   <= '0;
								strobe   <= 1'b1;
								result   <= '{ST_OK, '0, 1'b1};
							end
							CMD_PATTERN: begin
								n_q     <= cursor_q;
								b_q     <= item.data_byte;
								ret_q   <= INS_DO;
								state_q <= L_GOTO;
							end
							CMD_BUILD: begin
								head_q  <= '0;
								tail_q  <= '0;
								u_q     <= '0;
								bb_q    <= '0;
								root_q  <= 1'b1;
								state_q <= B_LK;
							end
							CMD_SCAN: begin
								n_q     <= scan_q;
								b_q     <= item.data_byte;
								ret_q   <= NN_CHK;
								nret_q  <= S_SET;
								state_q <= L_GOTO;
							end
							CMD_END: begin
								if (mask_q == '0) begin
									scan_q <= '0;
									strobe <= 1'b1;
									result <= '{ST_CLEAN, '0, 1'b1};
								end else begin
									id_q    <= '0;
									state_q <= E_W;
								end
							end
							default: begin
								strobe <= 1'b1;
								result <= '{ST_OK, '0, 1'b1};
							end
						endcase
					end
				end
				// edge lookup: goto read, parent check
				L_GOTO: state_q <= L_PRT;
				L_PRT: begin
					c_q     <= goto_rdata;
					state_q <= L_CHK;
				end
				L_CHK: begin
					if ((c_q != '0) && ({1'b0, c_q} < nc_q) && (prt_rdata == {n_q, b_q}))
						edge_q <= c_q;
					else
						edge_q <= '0;
					state_q <= ret_q;
				end
				// goto with failure fallback
				NN_CHK: begin
					if ((edge_q != '0) || (n_q == '0)) begin
						res_q   <= edge_q;
						state_q <= nret_q;
					end else begin
						state_q <= NN_FW;
					end
				end
				NN_FW: begin
					n_q     <= fail_rdata;
					state_q <= L_GOTO;
				end
				INS_DO: begin
					state_q <= IDLE;
					strobe  <= 1'b1;
					if ((edge_q == '0) && full) begin
						if (item_q.pattern_end) cursor_q <= '0;
						result <= '{ST_FULL, '0, 1'b1};
					end else begin
						if (edge_q == '0) nc_q <= nc_q + 1'b1;
						cursor_q <= item_q.pattern_end ? '0 : ((edge_q != '0) ? edge_q : new_node);
						result   <= '{ST_OK, '0, 1'b1};
					end
				end
				S_SET: begin
					scan_q  <= res_q;
					t_q     <= res_q;
					state_q <= S_T;
				end
				S_T: begin
					if (t_q == '0) begin
						strobe  <= 1'b1;
						result  <= '{ST_OK, '0, 1'b1};
						state_q <= IDLE;
					end else begin
						state_q <= S_R;
					end
				end
				S_R: begin
					if (tag_rdata[6]) mask_q <= mask_q | (64'd1 << tag_rdata[5:0]);
					t_q     <= fail_rdata;
					state_q <= S_T;
				end
				E_W: begin
					if (mask_q[id_q]) begin
						mask_q <= rem;
						strobe <= 1'b1;
						result <= '{ST_MATCH, id_q, (rem == '0)};
						if (rem == '0) begin
							scan_q  <= '0;
							state_q <= IDLE;
						end
					end
					id_q <= id_q + 1'b1;
				end
				// breadth-first failure link build
				B_LK: begin
					n_q     <= u_q;
					b_q     <= bb_q;
					ret_q   <= B_EDGE;
					state_q <= L_GOTO;
				end
				B_EDGE: begin
					if (edge_q != '0) begin
						if (tail_q < (NODE_W+1)'(NODE_COUNT)) tail_q <= tail_q + 1'b1;
						ch_q <= edge_q;
						if (root_q) begin
							state_q <= B_NEXTB;
						end else begin
							n_q     <= fu_q;
							b_q     <= bb_q;
							ret_q   <= NN_CHK;
							nret_q  <= B_WR;
							state_q <= L_GOTO;
						end
					end else begin
						state_q <= B_NEXTB;
					end
				end
				B_WR: state_q <= B_NEXTB;
				B_NEXTB: begin
					bb_q    <= bb_q + 1'b1;
					state_q <= (bb_q == 8'hFF) ? B_POP : B_LK;
				end
				B_POP: begin
					if (head_q == tail_q) begin
						cursor_q <= '0;
						strobe   <= 1'b1;
						result   <= '{ST_OK, '0, 1'b1};
						state_q  <= IDLE;
					end else begin
						head_q  <= head_q + 1'b1;
						state_q <= B_U;
					end
				end
				B_U: begin
					u_q     <= q_rdata;
					root_q  <= 1'b0;
					state_q <= B_FU;
				end
				B_FU: begin
					fu_q    <= fail_rdata;
					bb_q    <= '0;
					state_q <= B_LK;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

[dv/multi_pattern_byte_matcher_tb.sv]
// self-checking testbench for the multi-pattern byte matcher
module multi_pattern_byte_matcher_tb;
	import mpbm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		item_t it;
		bit    hold;
	} pending_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    strobe;
	result_t result;

	multi_pattern_byte_matcher uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .strobe(strobe), .result(result)
	);

	// shadow trie state
	bit [7:0]  trie_edge [NODE_COUNT*256];
	bit [7:0]  fail_link [NODE_COUNT];
	bit [6:0]  node_tag [NODE_COUNT];
	bit [7:0]  bfs_order [NODE_COUNT];
	int        used_nodes;
	int        ins_node;
	int        walk_node;
	bit [63:0] seen_ids;

	pending_t pending_q[$];
	result_t  expected_q[$];
	int       errors, cycles, accepted, match_cnt, cleans, fulls;
	int       gap_left;
	bit       draining;
	bit       quiet;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	task automatic report(input string what, input result_t got, input result_t want);
		$display("mismatch %s: got st=%0d id=%0d last=%0b want st=%0d id=%0d last=%0b at %0t",
			what, got.status, got.match_id, got.last, want.status, want.match_id,
			want.last, $realtime);
		errors++;
	endtask

	function automatic void wipe_trie();
		foreach (trie_edge[i]) trie_edge[i] = '0;
		foreach (fail_link[i]) fail_link[i] = '0;
		foreach (node_tag[i]) node_tag[i] = '0;
		used_nodes = 1;
		ins_node = 0;
		walk_node = 0;
		seen_ids = '0;
	endfunction

	function automatic int step_to(input int n, input int b);
		int guard;
		guard = 0;
		while (n != 0 && trie_edge[n*256+b] == 0 && guard < NODE_COUNT) begin
			n = fail_link[n];
			guard++;
		end
		return trie_edge[n*256+b];
	endfunction

	function automatic void link_failures();
		int head, tail, u, c;
		head = 0;
		tail = 0;
		for (int b = 0; b < 256; b++) begin
			c = trie_edge[b];
			if (c != 0 && tail < NODE_COUNT) begin
				fail_link[c] = '0;
				bfs_order[tail++] = 8'(c);
			end
		end
		while (head < tail) begin
			u = bfs_order[head++];
			for (int b = 0; b < 256; b++) begin
				c = trie_edge[u*256+b];
				if (c == 0) continue;
				if (tail < NODE_COUNT) bfs_order[tail++] = 8'(c);
				fail_link[c] = 8'(step_to(fail_link[u], b));
			end
		end
	endfunction

	function automatic void push_result(input logic [1:0] st, input int id, input bit lst);
		result_t r;
		r.status = st;
		r.match_id = 6'(id);
		r.last = lst;
		expected_q = {expected_q, r};
	endfunction

	function automatic void predict_matcher(input item_t it);
		int c, t, guard, n;
		case (it.cmd)
		CMD_CLEAR: begin
			wipe_trie();
			push_result(ST_OK, 0, 1);
		end
		CMD_PATTERN: begin
			c = trie_edge[ins_node*256+it.data_byte];
			if (c == 0 && used_nodes >= NODE_COUNT) begin
				if (it.pattern_end) ins_node = 0;
				push_result(ST_FULL, 0, 1);
			end else begin
				if (c == 0) begin
					c = used_nodes++;
					for (int b = 0; b < 256; b++) trie_edge[c*256+b] = '0;
					fail_link[c] = '0;
					node_tag[c] = '0;
					trie_edge[ins_node*256+it.data_byte] = 8'(c);
				end
				ins_node = c;
				if (it.pattern_end) begin
					if (it.pattern_id < PATTERN_COUNT) node_tag[c] = {1'b1, it.pattern_id};
					ins_node = 0;
				end
				push_result(ST_OK, 0, 1);
			end
		end
		CMD_BUILD: begin
			link_failures();
			ins_node = 0;
			push_result(ST_OK, 0, 1);
		end
		CMD_SCAN: begin
			walk_node = step_to(walk_node, it.data_byte);
			t = walk_node;
			guard = 0;
			while (t != 0 && guard < NODE_COUNT) begin
				if (node_tag[t][6]) seen_ids[node_tag[t][5:0]] = 1'b1;
				t = fail_link[t];
				guard++;
			end
			push_result(ST_OK, 0, 1);
		end
		CMD_END: begin
			n = $countones(seen_ids);
			if (n == 0) push_result(ST_CLEAN, 0, 1);
			for (int id = 0; id < 64; id++)
				if (seen_ids[id]) begin
					n--;
					push_result(ST_MATCH, id, n == 0);
				end
			seen_ids = '0;
			walk_node = 0;
		end
		default: push_result(ST_OK, 0, 1);
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// driver: transfer happens on start && !busy
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			gap_left = 0;
			draining = 0;
		end else begin
			if (start && !busy) begin
				predict_matcher(item);
				accepted++;
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (draining) begin
					if (expected_q.size() == 0) draining = 0;
					start <= 1'b0;
				end else if (pending_q.size() != 0) begin
					pending_t p;
					p = pending_q.pop_front();
					if (p.hold) begin
						draining = 1;
						start <= 1'b0;
					end else begin
						start <= 1'b1;
						item <= p.it;
						gap_left = pick_gap();
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_q.size() == 0) begin
				report("unexpected", result, '0);
			end else begin
				result_t want;
				want = expected_q.pop_front();
				if (result.status != want.status) report("status", result, want);
				if (result.match_id != want.match_id) report("match_id", result, want);
				if (result.last != want.last) report("last", result, want);
				if (result.status == ST_MATCH) match_cnt++;
				if (result.status == ST_CLEAN) cleans++;
				if (result.status == ST_FULL) fulls++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send(input logic [2:0] c, input int b, input bit pe, input int id);
		pending_t p;
		p.hold = 0;
		p.it.cmd = c;
		p.it.data_byte = 8'(b);
		p.it.pattern_end = pe;
		p.it.pattern_id = 6'(id);
		pending_q = {pending_q, p};
	endtask

	task automatic hold_off();
		pending_t p;
		p.hold = 1;
		p.it = '0;
		pending_q = {pending_q, p};
	endtask

	// one well-formed session with a small trie
	task automatic session(input bit late_insert);
		byte unsigned alpha [4];
		byte unsigned pats [3][$];
		int np, len, s;
		foreach (alpha[i]) alpha[i] = $urandom_range(255);
		send(CMD_CLEAR, $urandom_range(255), $urandom_range(1), $urandom_range(63));
		np = $urandom_range(3, 1);
		for (int p = 0; p < np; p++) begin
			len = $urandom_range(3, 1);
			pats[p] = {};
			for (int k = 0; k < len; k++) begin
				pats[p] = {pats[p], alpha[$urandom_range(3)]};
				send(CMD_PATTERN, pats[p][k], k == len - 1, $urandom_range(63));
			end
		end
		send(CMD_BUILD, $urandom_range(255), $urandom_range(1), $urandom_range(63));
		if (late_insert) begin
			send(CMD_PATTERN, alpha[0], 0, 0);
			send(CMD_PATTERN, alpha[1], 1, $urandom_range(63));
		end
		for (int r = 0; r < 2; r++) begin
			len = $urandom_range(6, 2);
			for (int k = 0; k < len; k++) begin
				s = $urandom_range(9);
				if (s < 4) begin
					// drop in a whole pattern
					int pk;
					pk = $urandom_range(np - 1);
					for (int j = 0; j < pats[pk].size(); j++)
						send(CMD_SCAN, pats[pk][j], $urandom_range(1), 0);
				end else if (s < 8) begin
					send(CMD_SCAN, alpha[$urandom_range(3)], 0, $urandom_range(63));
				end else if (s == 8) begin
					send(CMD_SCAN, $urandom_range(255), 1, 0);
				end else begin
					send(3'($urandom_range(7, 5)), $urandom_range(255), $urandom_range(1),
						$urandom_range(63));
				end
			end
			send(CMD_END, $urandom_range(255), $urandom_range(1), $urandom_range(63));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		errors = 0;
		cycles = 0;
		accepted = 0;
		match_cnt = 0;
		cleans = 0;
		fulls = 0;
		quiet = 0;
		wipe_trie();
		repeat (7) @(posedge clk);
		arst_n = 1'b1;

		// directed: extremes, overlaps, duplicate tag, unused codes
		send(CMD_END, 8'hff, 1, 63);
		send(CMD_PATTERN, 8'h00, 0, 0);
		send(CMD_PATTERN, 8'hff, 1, 0);
		send(CMD_PATTERN, 8'hff, 1, 63);
		send(CMD_PATTERN, 8'h00, 0, 5);
		send(CMD_PATTERN, 8'hff, 1, 7);       // duplicate overwrites id
		send(CMD_PATTERN, 8'h55, 1, 42);
		send(CMD_BUILD, 8'h00, 0, 0);
		send(CMD_SCAN, 8'h00, 0, 0);
		send(CMD_SCAN, 8'hff, 0, 0);
		send(CMD_SCAN, 8'hff, 0, 0);
		send(CMD_SCAN, 8'h55, 0, 0);
		send(CMD_END, 8'h00, 0, 0);
		send(3'd5, 8'haa, 1, 21);
		send(3'd6, 8'h55, 0, 42);
		send(3'd7, 8'hff, 1, 63);
		send(CMD_SCAN, 8'h12, 0, 0);
		send(CMD_END, 8'h00, 0, 0);
		hold_off();
		send(CMD_CLEAR, 8'h00, 0, 0);
		send(CMD_SCAN, 8'hff, 0, 0);
		send(CMD_END, 8'h00, 0, 0);

		// table full: distinct first bytes so the last byte finds no room
		for (int p = 0; p < 16; p++)
			for (int k = 0; k < 16; k++)
				send(CMD_PATTERN, (k == 0) ? p : $urandom_range(255), k == 15,
					$urandom_range(63));
		send(CMD_PATTERN, 8'h80, 0, 0);
		send(CMD_PATTERN, 8'h03, 1, 11);
		send(CMD_BUILD, 0, 0, 0);
		for (int k = 0; k < 4; k++) send(CMD_SCAN, $urandom_range(15), 0, 0);
		send(CMD_END, 0, 0, 0);
		hold_off();

		for (int s = 0; s < 2; s++) begin
			quiet = (s == 1);
			session($urandom_range(1) == 0);
		end
		send(CMD_CLEAR, 0, 0, 0);

		while (pending_q.size() != 0 || start || draining) @(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d commands, %0d match reports, %0d clean streams, %0d full-table hits",
			accepted, match_cnt, cleans, fulls);
		$display("finished in %0d cycles with %0d mismatches", cycles, errors);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[files.f]
hdl/mpbm_pkg.sv
hdl/mpbm_ram.sv
hdl/multi_pattern_byte_matcher.sv
dv/multi_pattern_byte_matcher_tb.sv
